>>> rtl/adts_flv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS to FLV repacker package
// Shared command format between parser and emitter, error codes and the
// fixed bytes of the FLV audio tag body.
// ----------------------------------------------------------------------------
package adts_flv_pkg;

    // error_code values
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SYNC  = 2'd1;
    localparam logic [1:0] ERR_TRUNC = 2'd2;
    localparam logic [1:0] ERR_SHORT = 2'd3;

    // ADTS header checks
    localparam logic [7:0] SYNC_BYTE0 = 8'hFF;
    localparam logic [7:0] SYNC_MASK1 = 8'hF6;
    localparam logic [7:0] SYNC_VAL1  = 8'hF0;

    // header lengths without / with CRC
    localparam logic [3:0] HDR_LEN_NO_CRC = 4'd7;
    localparam logic [3:0] HDR_LEN_CRC    = 4'd9;

    // FLV audio tag body bytes
    localparam logic [7:0] FLV_AAC_TAG  = 8'hAF;
    localparam logic [7:0] AAC_SEQ_HDR  = 8'h00;
    localparam logic [7:0] AAC_RAW      = 8'h01;

    // packet_kind values
    localparam logic KIND_SEQ = 1'b0;
    localparam logic KIND_RAW = 1'b1;

    // Result slots of one command, emitted lowest first
    localparam int NUM_SLOTS = 9;
    localparam logic [3:0] SLOT_SEQ_TAG   = 4'd0;
    localparam logic [3:0] SLOT_SEQ_TYPE  = 4'd1;
    localparam logic [3:0] SLOT_ASC0      = 4'd2;
    localparam logic [3:0] SLOT_ASC1      = 4'd3;
    localparam logic [3:0] SLOT_RAW_TAG   = 4'd4;
    localparam logic [3:0] SLOT_RAW_TYPE  = 4'd5;
    localparam logic [3:0] SLOT_DATA      = 4'd6;
    localparam logic [3:0] SLOT_ERR       = 4'd7;
    localparam logic [3:0] SLOT_TRUNC     = 4'd8;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // One parsed input byte, as the work it leaves for the emitter
    typedef struct packed {
        logic       seq;        // sequence header packet
        logic [7:0] asc0;
        logic [7:0] asc1;
        logic       raw;        // AF 01 opening of a raw packet
        logic       raw_empty;  // frame has no payload
        logic       data;       // one payload byte
        logic [7:0] data_byte;
        logic       data_last;
        logic       err;        // sync or short frame error
        logic [1:0] err_code;
        logic       trunc;      // stream ended inside a frame
    } cmd_t;

    function automatic slot_mask_t cmd_slots(input cmd_t c);
        slot_mask_t m;
        m = {c.trunc, c.err, c.data, c.raw, c.raw, c.seq, c.seq, c.seq, c.seq};
        return m;
    endfunction

endpackage

>>> rtl/adts_flv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS header parser
// Tracks frame position, checks sync and length, and turns each input word
// into a command for the emitter.
// ----------------------------------------------------------------------------
module adts_flv_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 stream_start,
    input  logic                 stream_end,
    output logic                 push,
    output adts_flv_pkg::cmd_t   cmd
);
    import adts_flv_pkg::*;

    typedef enum logic [1:0] {MODE_HUNT, MODE_HEADER, MODE_PAYLOAD, MODE_HALT} mode_t;

    mode_t       mode_reg, mode_next, mode_e;
    logic [12:0] pos_reg, pos_next, pos_e, pos;
    logic [12:0] flen_reg, flen_next, flen_e, flen_v, pos_inc;
    logic [15:0] hbits_reg, hbits_next, hbits_e;
    logic        crc_absent_reg, crc_absent_next, crc_e;
    logic        sent_reg, sent_next, sent_e;
    logic [3:0]  hlen;
    logic [2:0]  prof;
    logic [3:0]  sfi;
    logic [2:0]  chan;

    always_comb
    begin
        mode_e  = mode_reg;
        pos_e   = pos_reg;
        flen_e  = flen_reg;
        hbits_e = hbits_reg;
        crc_e   = crc_absent_reg;
        sent_e  = sent_reg;
        if (stream_start)
        begin
            mode_e  = MODE_HUNT;
            pos_e   = '0;
            flen_e  = '0;
            hbits_e = '0;
            crc_e   = 1'b1;
            sent_e  = 1'b0;
        end

        mode_next       = mode_e;
        pos_next        = pos_e;
        flen_next       = flen_e;
        hbits_next      = hbits_e;
        crc_absent_next = crc_e;
        sent_next       = sent_e;
        cmd             = '0;

        hlen    = crc_e ? HDR_LEN_NO_CRC : HDR_LEN_CRC;
        pos     = (mode_e == MODE_HEADER) ? pos_e : 13'd0;
        pos_inc = pos + 13'd1;
        flen_v  = flen_e | {10'd0, in_byte[7:5]};
        prof    = {1'b0, hbits_e[15:14]} + 3'd1;
        sfi     = hbits_e[13:10];
        chan    = {hbits_e[8], in_byte[7:6]};

        unique case (mode_e)
            MODE_HUNT, MODE_HEADER:
            begin
                mode_next = MODE_HEADER;
                pos_next  = pos_inc;
                if (pos == 13'd0)
                begin
                    if (in_byte != SYNC_BYTE0)
                    begin
                        cmd.err      = 1'b1;
                        cmd.err_code = ERR_SYNC;
                        mode_next    = MODE_HALT;
                    end
                end
                else if (pos == 13'd1)
                begin
                    if ((in_byte & SYNC_MASK1) != SYNC_VAL1)
                    begin
                        cmd.err      = 1'b1;
                        cmd.err_code = ERR_SYNC;
                        mode_next    = MODE_HALT;
                    end
                    else
                    begin
                        crc_absent_next = in_byte[0];
                    end
                end
                else if (pos == 13'd2)
                begin
                    hbits_next = {in_byte, 8'h00};
                end
                else if (pos == 13'd3)
                begin
                    hbits_next = {hbits_e[15:8], in_byte};
                    flen_next  = {in_byte[1:0], 11'd0};
                    if (!sent_e)
                    begin
                        cmd.seq   = 1'b1;
                        cmd.asc0  = {2'b00, prof, sfi[3:1]};
                        cmd.asc1  = {sfi[0], 1'b0, chan, 3'b000};
                        sent_next = 1'b1;
                    end
                end
                else if (pos == 13'd4)
                begin
                    flen_next = flen_e | {2'b00, in_byte, 3'b000};
                end
                else if (pos == 13'd5)
                begin
                    flen_next = flen_v;
                    if (flen_v < {9'd0, hlen})
                    begin
                        cmd.err      = 1'b1;
                        cmd.err_code = ERR_SHORT;
                        mode_next    = MODE_HALT;
                    end
                end

                if (mode_next == MODE_HEADER && pos == ({9'd0, hlen} - 13'd1))
                begin
                    cmd.raw       = 1'b1;
                    cmd.raw_empty = (flen_next == {9'd0, hlen});
                    if (cmd.raw_empty)
                    begin
                        mode_next = MODE_HUNT;
                        pos_next  = '0;
                    end
                    else
                    begin
                        mode_next = MODE_PAYLOAD;
                    end
                end
            end
            MODE_PAYLOAD:
            begin
                pos_next      = pos_e + 13'd1;
                cmd.data      = 1'b1;
                cmd.data_byte = in_byte;
                cmd.data_last = (pos_next >= flen_e);
                if (cmd.data_last)
                begin
                    mode_next = MODE_HUNT;
                    pos_next  = '0;
                end
            end
            MODE_HALT:
            begin
            end
        endcase

        if (stream_end)
        begin
            if (mode_next == MODE_HEADER || mode_next == MODE_PAYLOAD)
                cmd.trunc = 1'b1;
            mode_next       = MODE_HUNT;
            pos_next        = '0;
            flen_next       = '0;
            hbits_next      = '0;
            crc_absent_next = 1'b1;
            sent_next       = 1'b0;
        end

        push = accept && (cmd.seq || cmd.raw || cmd.data || cmd.err || cmd.trunc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_HUNT;
            pos_reg        <= '0;
            flen_reg       <= '0;
            hbits_reg      <= '0;
            crc_absent_reg <= 1'b1;
            sent_reg       <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            flen_reg       <= flen_next;
            hbits_reg      <= hbits_next;
            crc_absent_reg <= crc_absent_next;
            sent_reg       <= sent_next;
        end
    end

endmodule

>>> rtl/adts_flv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO between parser and emitter.
// ----------------------------------------------------------------------------
module adts_flv_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  adts_flv_pkg::cmd_t   push_cmd,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output adts_flv_pkg::cmd_t   head
);
    import adts_flv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (!push && do_pop)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/adts_flv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result emitter
// Expands queued commands into output words, one per cycle while out_stall
// is low, through an output register.
// ----------------------------------------------------------------------------
module adts_flv_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_not_empty,
    input  adts_flv_pkg::cmd_t   q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 packet_kind,
    output logic                 first_in_packet,
    output logic                 last_in_packet,
    output logic [1:0]           error_code
);
    import adts_flv_pkg::*;

    cmd_t       cmd_reg, src_cmd;
    slot_mask_t mask_reg, src_mask, rem_mask;
    logic       have_cur, load, emit;
    logic [3:0] slot;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       kind_reg, kind_next;
    logic       first_reg, first_next;
    logic       last_reg, last_next;
    logic [1:0] err_reg, err_next;

    always_comb
    begin
        have_cur = (mask_reg != '0);
        load     = !valid_reg || !out_stall;
        src_cmd  = have_cur ? cmd_reg : q_head;
        src_mask = have_cur ? mask_reg : (q_not_empty ? cmd_slots(q_head) : '0);
        rem_mask = src_mask & (src_mask - slot_mask_t'(1));
        emit     = load && (src_mask != '0);
        q_pop    = load && !have_cur && q_not_empty;

        // lowest pending slot
        slot = SLOT_TRUNC;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (src_mask[i])
                slot = 4'(i);
        end

        byte_next  = 8'h00;
        kind_next  = KIND_SEQ;
        first_next = 1'b0;
        last_next  = 1'b0;
        err_next   = ERR_NONE;
        unique case (slot)
            SLOT_SEQ_TAG:
            begin
                byte_next  = FLV_AAC_TAG;
                first_next = 1'b1;
            end
            SLOT_SEQ_TYPE: byte_next = AAC_SEQ_HDR;
            SLOT_ASC0:     byte_next = src_cmd.asc0;
            SLOT_ASC1:
            begin
                byte_next = src_cmd.asc1;
                last_next = 1'b1;
            end
            SLOT_RAW_TAG:
            begin
                byte_next  = FLV_AAC_TAG;
                kind_next  = KIND_RAW;
                first_next = 1'b1;
            end
            SLOT_RAW_TYPE:
            begin
                byte_next = AAC_RAW;
                kind_next = KIND_RAW;
                last_next = src_cmd.raw_empty;
            end
            SLOT_DATA:
            begin
                byte_next = src_cmd.data_byte;
                kind_next = KIND_RAW;
                last_next = src_cmd.data_last;
            end
            SLOT_ERR:
            begin
                last_next = 1'b1;
                err_next  = src_cmd.err_code;
            end
            SLOT_TRUNC:
            begin
                last_next = 1'b1;
                err_next  = ERR_TRUNC;
            end
            default:
            begin
            end
        endcase

        valid_next = load ? emit : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (emit)
                mask_reg <= rem_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_head;
        if (emit)
        begin
            byte_reg  <= byte_next;
            kind_reg  <= kind_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid       = valid_reg;
    assign out_byte        = byte_reg;
    assign packet_kind     = kind_reg;
    assign first_in_packet = first_reg;
    assign last_in_packet  = last_reg;
    assign error_code      = err_reg;

endmodule

>>> rtl/adts_to_flv_audio_repacker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS AAC to FLV audio tag repacker
// Parses an ADTS byte stream and emits FLV audio tag bodies word by word.
// ----------------------------------------------------------------------------
// The block takes one ADTS byte per cycle and never waits on its own work:
// an input word is taken every cycle while the command queue (QUEUE_DEPTH
// entries) has room. Results leave through a registered output at one word per
// unstalled cycle. The first valid header of a stream yields a 4-word sequence
// header (AF 00 plus AudioSpecificConfig) on header byte 3, each frame opens
// with AF 01 on its last header byte (7 bytes, 9 with CRC), and each payload
// byte comes out as one word. A byte may cause up to five words, so the output
// port's one word per cycle sets the sustained rate; header bytes that give no
// result absorb those bursts. A bad syncword or a frame length shorter than
// the header gives one error word and the parser ignores input until
// stream_start or stream_end; stream_end in an open frame appends a truncation
// word, and after stream_end the parser starts fresh on the next byte.
// ----------------------------------------------------------------------------
module adts_to_flv_audio_repacker_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // ADTS input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        stream_start,
    input  logic        stream_end,
    // FLV tag body words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        packet_kind,
    output logic        first_in_packet,
    output logic        last_in_packet,
    output logic [1:0]  error_code
);
    import adts_flv_pkg::*;

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic q_full, q_not_empty, q_pop;
    cmd_t q_head;

    // Front side only waits for queue space.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    adts_flv_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .stream_start (stream_start),
        .stream_end   (stream_end),
        .push         (push),
        .cmd          (push_cmd)
    );

    adts_flv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Back side drains the queue; it pops a command while emitting its
    // first word so consecutive payload bytes stream without gaps.
    adts_flv_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .packet_kind     (packet_kind),
        .first_in_packet (first_in_packet),
        .last_in_packet  (last_in_packet),
        .error_code      (error_code)
    );

endmodule
